>>> rtl/sks_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types, codes and key mapping for the segmented key sorter.
// ----------------------------------------------------------------------------
package sks_pkg;

    localparam int unsigned ELEM_W = 64;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned KIND_W = 3;

    localparam logic [0:0] CFG_SEG_LEN   = 1'b0;
    localparam logic [0:0] CFG_ELEM_KIND = 1'b1;

    localparam logic [KIND_W-1:0] KIND_UNSIGNED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SIGNED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FLOAT32  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FLOAT64  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COMPLEX  = 3'd4;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [ELEM_W-1:0] sorted_value;
        logic              segment_last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // Cell control, broadcast along the row.
    typedef struct packed {
        logic insert;   // new key enters the row
        logic shift;    // row moves one place toward the head
        logic flush;    // drop all contents
    } t_cell_ctl;

    function automatic logic [31:0] key32(input logic [31:0] b);
        return b[31] ? ~b : {1'b1, b[30:0]};
    endfunction

    function automatic logic [ELEM_W-1:0] elem_key(input logic [KIND_W-1:0] kind,
                                                   input logic [ELEM_W-1:0] v);
        logic [ELEM_W-1:0] k;
        k = v;
        unique case (kind)
            KIND_SIGNED:  k = {~v[63], v[62:0]};
            KIND_FLOAT32: k = {32'd0, key32(v[31:0])};
            KIND_FLOAT64: k = v[63] ? ~v : {1'b1, v[62:0]};
            KIND_COMPLEX: k = {key32(v[63:32]), key32(v[31:0])};
            default:      k = v;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

>>> rtl/sks_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sks_cell
// One sorting cell: holds a key/value, keeps the smaller (or the earlier, if ordered), passes the rest on.
// ----------------------------------------------------------------------------
module sks_cell
    import sks_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic              i_ordered,   // keep arrival order, no compare
    // from the previous cell (insert path)
    input  wire logic              i_prev_valid,
    input  wire logic [ELEM_W-1:0] i_prev_key,
    input  wire logic [ELEM_W-1:0] i_prev_val,
    input  wire logic              i_prev_disp,  // previous cell gives way to the new key
    // incoming key broadcast
    input  wire logic [ELEM_W-1:0] i_new_key,
    input  wire logic [ELEM_W-1:0] i_new_val,
    // from the next cell (shift path)
    input  wire logic              i_next_valid,
    input  wire logic [ELEM_W-1:0] i_next_key,
    input  wire logic [ELEM_W-1:0] i_next_val,
    output logic                   o_valid,
    output logic [ELEM_W-1:0]      o_key,
    output logic [ELEM_W-1:0]      o_val,
    output logic                   o_disp
);

    logic              r_valid;
    logic [ELEM_W-1:0] r_key;
    logic [ELEM_W-1:0] r_val;
    logic              w_take;

    // A slot gives way if it is empty or, unless i_ordered, holds a strictly
    // greater key (equal keys stay ahead: stable). Filled slots form a prefix in
    // key order (arrival order if i_ordered), so the first slot that gives way
    // takes the new key and every later slot takes its neighbor's old content.
    assign o_disp = !r_valid || (!i_ordered && (r_key > i_new_key));
    assign w_take = !i_prev_disp && o_disp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.flush) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
            r_key   <= i_next_key;
            r_val   <= i_next_val;
        end else if (i_ctl.insert) begin
            if (i_prev_disp) begin
                r_valid <= i_prev_valid;
                r_key   <= i_prev_key;
                r_val   <= i_prev_val;
            end else if (w_take) begin
                r_valid <= 1'b1;
                r_key   <= i_new_key;
                r_val   <= i_new_val;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_val   = r_val;

endmodule
`default_nettype wire

>>> rtl/segmented_key_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_key_sorter
// Stream sorter: insertion into two rows of compare cells, drained from the head.
// ----------------------------------------------------------------------------
// Latency: an item enters the row at the edge that takes it. The item that
//   closes a segment (full, or end_of_data) starts the drain; the first result
//   is offered in the next cycle and results leave one per cycle while ready.
// Throughput: one item per cycle while filling; none is taken while draining.
// Reset: synchronous, active low; empties both rows, seg_len=64, elem_kind=0.
// ----------------------------------------------------------------------------
module segmented_key_sorter
    import sks_pkg::*;
#(
    parameter int unsigned SEG_MAX = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [LEN_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_item
);

    localparam int unsigned CNT_W = $clog2(SEG_MAX + 1);

    logic [LEN_W-1:0]  r_seg_len;
    logic [KIND_W-1:0] r_kind;
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_ordered, n_ordered;  // drain in arrival order
    logic [CNT_W-1:0]  w_len;
    t_cell_ctl         w_ctl;
    logic [ELEM_W-1:0] w_new_key;
    logic              w_acc;
    logic              w_pop;

    // Row signals; index SEG_MAX is the empty tail.
    logic              w_valid [0:SEG_MAX];
    logic [ELEM_W-1:0] w_key   [0:SEG_MAX];
    logic [ELEM_W-1:0] w_val   [0:SEG_MAX];
    logic              w_disp  [0:SEG_MAX];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len <= LEN_W'(64);
            r_kind    <= KIND_UNSIGNED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEG_LEN:   r_seg_len <= i_cfg_data;
                CFG_ELEM_KIND: r_kind    <= i_cfg_data[KIND_W-1:0];
                default:       ;
            endcase
        end
    end

    // Effective length: 0 acts as 1, clipped to SEG_MAX.
    always_comb begin
        if (r_seg_len == '0)
            w_len = CNT_W'(1);
        else if (32'(r_seg_len) > SEG_MAX)
            w_len = CNT_W'(SEG_MAX);
        else
            w_len = CNT_W'(r_seg_len);
    end

    assign w_new_key = elem_key(r_kind, i_in_item.element);
    assign w_acc     = i_in_valid && o_in_ready;
    assign w_pop     = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_fill    <= '0;
            r_ordered <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_ordered <= n_ordered;
        end
    end

    // Fill: every item is inserted into two rows, one kept sorted and one in
    // arrival order. A full segment drains the sorted row; a short segment
    // closed by end_of_data drains the arrival-order row.
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_ordered = r_ordered;
        w_ctl     = '0;
        o_in_ready = (r_state == ST_FILL);
        unique case (r_state)
            ST_FILL: begin
                if (w_acc) begin
                    w_ctl.insert = 1'b1;
                    n_fill = r_fill + CNT_W'(1);
                    if (n_fill >= w_len || i_in_item.end_of_data) begin
                        n_state   = ST_DRAIN;
                        n_ordered = (n_fill < w_len);
                    end
                end
            end
            ST_DRAIN: begin
                if (w_pop) begin
                    w_ctl.shift = 1'b1;
                    n_fill = r_fill - CNT_W'(1);
                    if (r_fill == CNT_W'(1)) begin
                        n_state   = ST_FILL;
                        n_ordered = 1'b0;
                    end
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // Two rows: sorted row and arrival-order row share cell type.
    logic              a_valid [0:SEG_MAX];
    logic [ELEM_W-1:0] a_key   [0:SEG_MAX];
    logic [ELEM_W-1:0] a_val   [0:SEG_MAX];
    logic              a_disp  [0:SEG_MAX];

    assign w_valid[SEG_MAX] = 1'b0;
    assign w_key[SEG_MAX]   = '0;
    assign w_val[SEG_MAX]   = '0;
    assign a_valid[SEG_MAX] = 1'b0;
    assign a_key[SEG_MAX]   = '0;
    assign a_val[SEG_MAX]   = '0;

    for (genvar g = 0; g < SEG_MAX; g++) begin : g_row
        logic              p_valid, p_disp, q_valid, q_disp;
        logic [ELEM_W-1:0] p_key, p_val, q_key, q_val;
        if (g == 0) begin : g_head
            assign p_valid = 1'b0; assign p_key = '0; assign p_val = '0;
            assign p_disp  = 1'b0;
            assign q_valid = 1'b0; assign q_key = '0; assign q_val = '0;
            assign q_disp  = 1'b0;
        end else begin : g_body
            assign p_valid = w_valid[g-1]; assign p_key = w_key[g-1];
            assign p_val   = w_val[g-1];   assign p_disp = w_disp[g-1];
            assign q_valid = a_valid[g-1]; assign q_key = a_key[g-1];
            assign q_val   = a_val[g-1];   assign q_disp = a_disp[g-1];
        end
        sks_cell u_sort (
            .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_ordered(1'b0),
            .i_prev_valid(p_valid), .i_prev_key(p_key), .i_prev_val(p_val),
            .i_prev_disp(p_disp),
            .i_new_key(w_new_key), .i_new_val(i_in_item.element),
            .i_next_valid(w_valid[g+1]), .i_next_key(w_key[g+1]),
            .i_next_val(w_val[g+1]),
            .o_valid(w_valid[g]), .o_key(w_key[g]), .o_val(w_val[g]),
            .o_disp(w_disp[g])
        );
        sks_cell u_arr (
            .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_ordered(1'b1),
            .i_prev_valid(q_valid), .i_prev_key(q_key), .i_prev_val(q_val),
            .i_prev_disp(q_disp),
            .i_new_key(w_new_key), .i_new_val(i_in_item.element),
            .i_next_valid(a_valid[g+1]), .i_next_key(a_key[g+1]),
            .i_next_val(a_val[g+1]),
            .o_valid(a_valid[g]), .o_key(a_key[g]), .o_val(a_val[g]),
            .o_disp(a_disp[g])
        );
    end

    // Head of the chosen row is the result.
    assign o_out_valid             = (r_state == ST_DRAIN);
    assign o_out_item.sorted_value = r_ordered ? a_val[0] : w_val[0];
    assign o_out_item.segment_last = (r_fill == CNT_W'(1));

    // Draining always has a valid entry at the head of both rows.
    a_drain_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (w_valid[0] && a_valid[0]))
        else $error("drain with empty row head");

    // Count never exceeds the row size.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= SEG_MAX)
        else $error("fill count out of range");

    // Input is never taken while draining.
    a_no_take_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> !o_in_ready)
        else $error("input taken while draining");

endmodule
`default_nettype wire

>>> verif/tb_segmented_key_sorter.sv
// ----------------------------------------------------------------------------
// tb_segmented_key_sorter
// Drives element streams through the sorter under several segment lengths and
// element kinds, predicts each emitted segment in the bench and compares every
// result item field by field, under a range of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_segmented_key_sorter;
    import sks_pkg::*;

    localparam int SEG_MAX   = 64;
    localparam int WDOG_MAX  = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [LEN_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_ready;
    t_out_item o_out_item;

    segmented_key_sorter #(.SEG_MAX(SEG_MAX)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_item(o_out_item)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Bench copy of the sorter state and settings.
    logic [ELEM_W-1:0] pending_elems[$];
    int unsigned       len_setting;
    logic [KIND_W-1:0] kind_setting;
    t_out_item         sorted_expect[$];

    int errors;
    int items_sent;
    int results_seen;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;

    // Ordering key, IEEE total order for float parts.
    function automatic logic [31:0] fkey32(logic [31:0] b);
        return b[31] ? ~b : (b | 32'h8000_0000);
    endfunction

    function automatic logic [63:0] order_key(logic [63:0] v);
        case (kind_setting)
            KIND_SIGNED:  return v ^ 64'h8000_0000_0000_0000;
            KIND_FLOAT32: return {32'd0, fkey32(v[31:0])};
            KIND_FLOAT64: return v[63] ? ~v : (v | 64'h8000_0000_0000_0000);
            KIND_COMPLEX: return {fkey32(v[63:32]), fkey32(v[31:0])};
            default:      return v;
        endcase
    endfunction

    // Update state with one accepted item, queue the results it causes.
    task automatic predict_segment(input t_in_item it);
        logic [63:0] vals[$];
        logic [63:0] keys[$];
        logic [63:0] k;
        int unsigned eff;
        int j;
        t_out_item o;
        if (pending_elems.size() >= SEG_MAX)
            pending_elems = pending_elems[0:SEG_MAX-2];
        pending_elems.push_back(it.element);
        eff = (len_setting == 0) ? 1 : (len_setting > SEG_MAX ? SEG_MAX : len_setting);
        if (pending_elems.size() >= eff) begin
            // stable insertion sort
            foreach (pending_elems[i]) begin
                k = order_key(pending_elems[i]);
                j = vals.size();
                while (j > 0 && keys[j-1] > k) j--;
                vals.insert(j, pending_elems[i]);
                keys.insert(j, k);
            end
        end else if (it.end_of_data) begin
            vals = pending_elems;
        end else begin
            return;
        end
        foreach (vals[i]) begin
            o.sorted_value = vals[i];
            o.segment_last = (i == vals.size() - 1);
            sorted_expect.push_back(o);
        end
        pending_elems.delete();
    endtask

    // Result checker and receiver stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (sorted_expect.size() == 0) begin
                $error("unexpected result item %h", o_out_item);
                errors++;
            end else begin
                t_out_item e;
                e = sorted_expect.pop_front();
                if (o_out_item.sorted_value !== e.sorted_value) begin
                    $error("sorted_value: expected %h actual %h",
                           e.sorted_value, o_out_item.sorted_value);
                    errors++;
                end
                if (o_out_item.segment_last !== e.segment_last) begin
                    $error("segment_last: expected %0d actual %0d",
                           e.segment_last, o_out_item.segment_last);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: cycles with no accepted item on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired");
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Send one item; accepted at a rising edge with ready high. Valid stays
    // high afterward until the next item, an idle cycle or a register write.
    task automatic send_item(input logic [63:0] elem, input logic eod);
        t_in_item it;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        it.element = elem;
        it.end_of_data = eod;
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        // ready only moves at a rising edge, so the value here holds at the next one
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        predict_segment(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Wait for all results, then let the drain settle before a write.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sorted_expect.size() != 0) @(negedge i_clk);
        repeat (2 * SEG_MAX + 8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int unsigned val);
        i_in_valid  <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[LEN_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_SEG_LEN) len_setting = val & 7'h7F;
        else kind_setting = val[KIND_W-1:0];
    endtask

    task automatic configure(input int unsigned len, input logic [KIND_W-1:0] kind);
        wait_drained();
        write_reg(CFG_SEG_LEN, len);
        write_reg(CFG_ELEM_KIND, kind);
    endtask

    // Random element with a bias toward interesting float patterns.
    function automatic logic [31:0] rand_f32();
        case ($urandom_range(7))
            0: return {1'($urandom_range(1)), 31'h7F80_0000};      // infinities
            1: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 8))};
            2: return {1'($urandom_range(1)), 31'd0};              // signed zeros
            3: return {1'($urandom_range(1)), 8'h3F, 23'($urandom_range(3))};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_elem();
        case (kind_setting)
            KIND_FLOAT32, KIND_COMPLEX:
                return {rand_f32(), rand_f32()};
            KIND_FLOAT64:
                case ($urandom_range(4))
                    0: return {1'($urandom_range(1)), 11'h7FF, 52'd0};
                    1: return {1'($urandom_range(1)), 63'd0};
                    2: return {1'($urandom_range(1)), 11'h7FF, 52'($urandom_range(1, 9))};
                    default: return {$urandom, $urandom};
                endcase
            default:
                // small range gives repeated keys (and repeated values)
                return ($urandom_range(3) == 0) ? 64'($urandom_range(7)) :
                       {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_segments(input int count, input int eod_pct);
        for (int i = 0; i < count; i++)
            send_item(rand_elem(), $urandom_range(99) < eod_pct);
    endtask

    // ---- tests ----

    task automatic test_unsigned_extremes();
        configure(4, KIND_UNSIGNED);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(64'h0, 1'b0);
        send_item(64'h5555_5555_5555_5555, 1'b0);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        // equal keys (identical values, so their arrival order is not visible)
        send_item(64'd3, 1'b0);
        send_item(64'd3, 1'b0);
        send_item(64'd1, 1'b0);
        send_item(64'd3, 1'b0);
    endtask

    task automatic test_signed_and_floats();
        configure(3, KIND_SIGNED);
        send_item(64'h8000_0000_0000_0000, 1'b0);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        // float32: upper bits ignored, kept in output
        configure(4, KIND_FLOAT32);
        send_item(64'h1234_5678_8000_0000, 1'b0);  // -0
        send_item(64'hFFFF_FFFF_0000_0000, 1'b0);  // +0
        send_item(64'h0000_0000_FFC0_0000, 1'b0);  // -NaN
        send_item(64'h0000_0000_7F80_0000, 1'b0);  // +inf
        configure(3, KIND_FLOAT64);
        send_item(64'h7FF8_0000_0000_0000, 1'b0);
        send_item(64'hFFF0_0000_0000_0000, 1'b0);
        send_item(64'h8000_0000_0000_0000, 1'b0);
        configure(3, KIND_COMPLEX);
        send_item(64'h3F80_0000_4000_0000, 1'b0);
        send_item(64'h3F80_0000_BF80_0000, 1'b0);
        send_item(64'hBF80_0000_7F80_0000, 1'b0);
    endtask

    task automatic test_length_corners();
        configure(0, 3'd7);             // zero length acts as one; undefined kind
        send_item(64'hDEAD_BEEF_0000_0001, 1'b0);
        send_item(64'h1, 1'b1);
        configure(127, KIND_UNSIGNED);  // clamps to the row size
        for (int i = 0; i < SEG_MAX; i++) send_item(rand_elem(), 1'b0);
        configure(5, KIND_UNSIGNED);    // partial remainder at end of data
        send_item(64'd9, 1'b0);
        send_item(64'd2, 1'b1);
        send_item(64'd8, 1'b0);         // full segment on end of data
        send_item(64'd7, 1'b0);
        send_item(64'd6, 1'b0);
        send_item(64'd5, 1'b0);
        send_item(64'd4, 1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned lens[5] = '{1, 2, 7, 16, SEG_MAX};
        int unsigned per_phase;
        per_phase = 30;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                3: begin send_idle_pct = 16; recv_stall_pct = 16; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            configure(ph == 4 ? lens[$urandom_range(4)] : lens[ph],
                      KIND_UNSIGNED + KIND_W'($urandom_range(4)));
            send_segments(per_phase - 1, 6);
            // close the phase so nothing is pending across a register write
            send_item(rand_elem(), 1'b1);
        end
        // length lowered mid-segment: the next item closes one sorted segment with all pending items
        configure(16, KIND_FLOAT32);
        send_segments(10, 0);
        write_reg(CFG_SEG_LEN, 4);
        send_segments(6, 0);
        send_item(rand_elem(), 1'b1);
    endtask

    initial begin
        errors = 0; items_sent = 0; results_seen = 0; idle_cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_in_item = '0; i_out_ready = 1'b0;
        len_setting = 64; kind_setting = KIND_UNSIGNED;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_unsigned_extremes();
        test_signed_and_floats();
        test_length_corners();
        test_random_traffic();

        wait_drained();

        $display("sent %0d items, checked %0d results over all kinds and lengths",
                 items_sent, results_seen);
        $display("idling phases: none, sender 85%%, receiver 85%%, both 16%%");
        if (errors == 0 && sorted_expect.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sks_pkg.sv
rtl/sks_cell.sv
rtl/segmented_key_sorter.sv
verif/tb_segmented_key_sorter.sv
